/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the string decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ESCD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define ESCD_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

/* hw/rtl/escd_pkg.sv */
// Types and constants of the escaped string decoder.
package escd_pkg;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_STR  = 3'd1,
		PH_ESC  = 3'd2,
		PH_HEXF = 3'd3,
		PH_HEX  = 3'd4,
		PH_OCT  = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		K_BYTE      = 2'd0,
		K_CLOSED    = 2'd1,
		K_UNMATCHED = 2'd2,
		K_NULLERR   = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] val;
		kind_t      kind;
	} res_t;

	typedef struct packed {
		res_t r0;
		res_t r1;
		logic two;
	} entry_t;

	localparam int FIFO_DEPTH = 2;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_DQUOT = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_V     = 8'h76;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_7     = 8'h37;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;

	localparam logic [7:0] BY_NL  = 8'd10;
	localparam logic [7:0] BY_TAB = 8'd9;
	localparam logic [7:0] BY_VT  = 8'd11;
	localparam logic [7:0] BY_BS  = 8'd8;
	localparam logic [7:0] BY_CR  = 8'd13;
	localparam logic [7:0] BY_FF  = 8'd12;
	localparam logic [7:0] BY_BEL = 8'd7;

endpackage

/* hw/rtl/escd_in_if.sv */
// Character input channel of the escaped string decoder.
interface escd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       start_req;

	modport source (output valid, output in_char, output start_req, input ready);
	modport sink (input valid, input in_char, input start_req, output ready);
endinterface

/* hw/rtl/escd_out_if.sv */
// Result output channel of the escaped string decoder.
interface escd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] kind;
	logic       last;

	modport source (output valid, output out_byte, output kind, output last, input ready);
	modport sink (input valid, input out_byte, input kind, input last, output ready);
endinterface

/* hw/rtl/escaped_string_decoder_core.sv */
// Top level of the escaped string decoder.
// Decodes a quoted string with C-style escapes, one character per beat on chr.
// A beat with start_req set carries the opening quote and begins a new string.
// Each character beat gives zero, one or two result beats on res; last marks
// the final result of that character. kind: 0 byte, 1 closed, 2 unmatched
// quote, 3 null character error. Characters outside a string give nothing.
// A result is registered in the queue when its character beat is accepted.
// Throughput: one character per cycle while chr.ready is high; a character
// that ends a number escape and also gives its own result takes two output
// beats. The rate is set by the escape state machine in the front end and by
// the one-beat-per-cycle output stage.
// A two-entry queue sits between the front end and the output stage, so chr
// stays ready while a result waits on res. When res stalls the queue fills
// and chr.ready drops after two pending entries; nothing is lost.
// Reset clears the state machine to idle and empties the queue.
module escaped_string_decoder_core (
	input  logic       clk,
	input  logic       arst_n,
	escd_in_if.sink    chr,
	escd_out_if.source res
);
	import escd_pkg::*;

	entry_t push_data;
	entry_t head;
	logic   push;
	logic   pop;
	logic   empty;
	logic   full;

	escd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.chr       (chr),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	escd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	escd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.res    (res)
	);

endmodule

/* hw/rtl/escd_front.sv */
// Front end: accepts characters, runs the escape state machine, builds result entries.
module escd_front (
	input  logic            clk,
	input  logic            arst_n,
	escd_in_if.sink         chr,
	input  logic            full,
	output logic            push,
	output escd_pkg::entry_t push_data
);
	import escd_pkg::*;

	`include "assert_macros.svh"

	typedef struct packed {
		logic   emit;
		res_t   res;
		phase_t ph;
	} sc_t;

	phase_t     ph_q, ph_d;
	logic [7:0] num_q, num_d;
	logic       nz_q, nz_d;
	logic [7:0] c;
	logic       acc;
	logic [3:0] hd;
	logic       hex_ok;
	logic       oct_ok;
	sc_t        sc_w;
	res_t       r0, r1;
	logic [1:0] cnt;

	function automatic res_t mk(kind_t k, logic [7:0] v);
		res_t r;
		r.kind = k;
		r.val  = (k == K_BYTE) ? v : 8'd0;
		return r;
	endfunction

	function automatic sc_t str_char(logic [7:0] ch);
		sc_t s;
		s.emit = 1'b1;
		s.ph   = PH_STR;
		s.res  = mk(K_BYTE, ch);
		if (ch == CH_NUL) begin
			s.ph  = PH_IDLE;
			s.res = mk(K_UNMATCHED, 8'd0);
		end else if (ch == CH_DQUOT) begin
			s.ph  = PH_IDLE;
			s.res = mk(K_CLOSED, 8'd0);
		end else if (ch == CH_BSL) begin
			s.ph   = PH_ESC;
			s.emit = 1'b0;
		end
		return s;
	endfunction

	assign c      = chr.in_char;
	assign chr.ready = !full;
	assign acc    = chr.valid && chr.ready;
	assign sc_w   = str_char(c);
	assign oct_ok = (c >= CH_0) && (c <= CH_7);

	always_comb begin
		hex_ok = 1'b1;
		hd     = 4'd0;
		if (c >= CH_0 && c <= CH_9) begin
			hd = c[3:0];
		end else if (c >= CH_LA && c <= CH_LF) begin
			hd = 4'(c - CH_LA + 8'd10);
		end else if (c >= CH_UA && c <= CH_UF) begin
			hd = 4'(c - CH_UA + 8'd10);
		end else begin
			hex_ok = 1'b0;
		end
	end

	always_comb begin
		ph_d  = ph_q;
		num_d = num_q;
		nz_d  = nz_q;
		if (chr.start_req) begin
			ph_d  = PH_STR;
			num_d = 8'd0;
			nz_d  = 1'b0;
		end else begin
			unique case (ph_q)
				PH_STR: begin
					ph_d = sc_w.ph;
				end
				PH_ESC: begin
					ph_d = PH_STR;
					if (c == CH_NUL) begin
						ph_d = PH_IDLE;
					end else if (c == CH_X) begin
						ph_d  = PH_HEXF;
						num_d = 8'd0;
						nz_d  = 1'b0;
					end else if (oct_ok) begin
						ph_d  = PH_OCT;
						num_d = {5'd0, c[2:0]};
						nz_d  = (c != CH_0);
					end
				end
				PH_HEXF, PH_HEX: begin
					if (hex_ok) begin
						ph_d  = PH_HEX;
						num_d = {num_q[3:0], hd};
						nz_d  = nz_q || (hd != 4'd0);
					end else if (ph_q == PH_HEXF || !nz_q) begin
						ph_d = PH_IDLE;
					end else begin
						ph_d = sc_w.ph;
					end
				end
				PH_OCT: begin
					if (oct_ok) begin
						num_d = {num_q[4:0], c[2:0]};
						nz_d  = nz_q || (c != CH_0);
					end else if (!nz_q) begin
						ph_d = PH_IDLE;
					end else begin
						ph_d = sc_w.ph;
					end
				end
				default: begin
					ph_d = PH_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		r0  = mk(K_BYTE, 8'd0);
		r1  = mk(K_BYTE, 8'd0);
		cnt = 2'd0;
		if (chr.start_req) begin
			r0  = mk(K_BYTE, c);
			cnt = 2'd1;
		end else begin
			unique case (ph_q)
				PH_STR: begin
					r0  = sc_w.res;
					cnt = sc_w.emit ? 2'd1 : 2'd0;
				end
				PH_ESC: begin
					cnt = 2'd1;
					unique case (c) inside
						CH_NUL:      r0 = mk(K_NULLERR, 8'd0);
						CH_N:        r0 = mk(K_BYTE, BY_NL);
						CH_T:        r0 = mk(K_BYTE, BY_TAB);
						CH_V:        r0 = mk(K_BYTE, BY_VT);
						CH_B:        r0 = mk(K_BYTE, BY_BS);
						CH_R:        r0 = mk(K_BYTE, BY_CR);
						CH_F:        r0 = mk(K_BYTE, BY_FF);
						CH_A:        r0 = mk(K_BYTE, BY_BEL);
						CH_X:        cnt = 2'd0;
						[CH_0:CH_7]: cnt = 2'd0;
						default:     r0 = mk(K_BYTE, c);
					endcase
				end
				PH_HEXF, PH_HEX, PH_OCT: begin
					if ((ph_q == PH_OCT) ? oct_ok : hex_ok) begin
						cnt = 2'd0;
					end else if (ph_q == PH_HEXF || !nz_q) begin
						r0  = mk(K_NULLERR, 8'd0);
						cnt = 2'd1;
					end else begin
						r0  = mk(K_BYTE, num_q);
						r1  = sc_w.res;
						cnt = sc_w.emit ? 2'd2 : 2'd1;
					end
				end
				default: begin
					cnt = 2'd0;
				end
			endcase
		end
	end

	assign push          = acc && (cnt != 2'd0);
	assign push_data.r0  = r0;
	assign push_data.r1  = r1;
	assign push_data.two = (cnt == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_IDLE;
			num_q <= 8'd0;
			nz_q  <= 1'b0;
		end else if (acc) begin
			ph_q  <= ph_d;
			num_q <= num_d;
			nz_q  <= nz_d;
		end
	end

	`ESCD_ASSERT(a_hexf_clear, (ph_q == PH_HEXF) |-> (!nz_q && num_q == 8'd0), "hex start not clear")

endmodule

/* hw/rtl/escd_fifo.sv */
// Short result queue between the front end and the output stage.
module escd_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  escd_pkg::entry_t push_data,
	input  logic             pop,
	output escd_pkg::entry_t head,
	output logic             empty,
	output logic             full
);
	import escd_pkg::*;

	`include "assert_macros.svh"

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	entry_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q;
	logic [CNT_W-1:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CNT_W'(FIFO_DEPTH));
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`ESCD_ASSERT(a_no_overflow, push |-> !full, "push into full queue")
	`ESCD_ASSERT(a_no_underflow, pop |-> !empty, "pop from empty queue")

endmodule

/* hw/rtl/escd_back.sv */
// Output stage: sends one or two results of each queue entry as beats.
module escd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  escd_pkg::entry_t head,
	input  logic             empty,
	output logic             pop,
	escd_out_if.source       res
);
	import escd_pkg::*;

	`include "assert_macros.svh"

	logic sel_q;
	res_t cur;
	logic beat;
	logic lst;

	assign cur          = sel_q ? head.r1 : head.r0;
	assign lst          = !head.two || sel_q;
	assign res.valid    = !empty;
	assign res.out_byte = cur.val;
	assign res.kind     = cur.kind;
	assign res.last     = lst;
	assign beat         = res.valid && res.ready;
	assign pop          = beat && lst;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
		end else if (beat) begin
			sel_q <= !lst;
		end
	end

	`ESCD_ASSERT(a_sel_pair, sel_q |-> (!empty && head.two), "second slot without pair")
	`ESCD_ASSERT_NEXT(a_pair_adv, (beat && !lst), sel_q, "pair did not advance")

endmodule

/* tb/sv/escaped_string_decoder_core_tb.sv */
// Self-checking testbench of the escaped string decoder core: random strings, stalls, predictor.
module escaped_string_decoder_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import escd_pkg::*;

	localparam int NUM_ITEMS  = 1400;
	localparam int HOLD_LEN   = 160;
	localparam int IDLE_LIMIT = 2000;
	localparam int TAIL_WAIT  = 20;

	typedef struct {
		logic [7:0] ch;
		logic       st;
		logic       drain;
	} chr_beat_t;

	typedef struct {
		logic [7:0] val;
		kind_t      kind;
		logic       last;
	} dec_res_t;

	logic clk = 1'b0;
	logic arst_n;

	escd_in_if  chr_if ();
	escd_out_if res_if ();

	escaped_string_decoder_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.chr    (chr_if),
		.res    (res_if)
	);

	chr_beat_t  pending_chars[$];
	dec_res_t   decoded_q[$];

	phase_t     ph = PH_IDLE;
	logic [7:0] num_val = 8'd0;
	logic       num_nz = 1'b0;

	int         n_err;
	int         n_chr;
	int         n_gen;
	int         burst_left;
	int         gap_left;
	int         hold_left;
	bit         held_once;
	int         stall_mode;
	logic [5:0] pat_cnt;
	int         idle_cnt;
	logic       drive_v;
	logic       ready_nxt;
	chr_beat_t  nxt_beat;
	dec_res_t   exp_res;

	string      hex_digits = "0123456789abcdefABCDEF";
	string      esc_set    = "ntvbrfa\\?'\"";

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int hex_val(logic [7:0] c);
		if (c >= CH_0 && c <= CH_9)
			return int'(c) - int'(CH_0);
		if (c >= CH_LA && c <= CH_LF)
			return int'(c) - int'(CH_LA) + 10;
		if (c >= CH_UA && c <= CH_UF)
			return int'(c) - int'(CH_UA) + 10;
		return -1;
	endfunction

	task automatic add_result(kind_t k, logic [7:0] b);
		dec_res_t r;
		r.val  = (k == K_BYTE) ? b : 8'd0;
		r.kind = k;
		r.last = 1'b0;
		decoded_q.push_back(r);
	endtask

	task automatic in_string(logic [7:0] c);
		if (c == CH_NUL) begin
			ph = PH_IDLE;
			add_result(K_UNMATCHED, 8'd0);
		end else if (c == CH_DQUOT) begin
			ph = PH_IDLE;
			add_result(K_CLOSED, 8'd0);
		end else if (c == CH_BSL) begin
			ph = PH_ESC;
		end else begin
			add_result(K_BYTE, c);
		end
	endtask

	task automatic close_number(logic [7:0] c);
		if (!num_nz) begin
			ph = PH_IDLE;
			add_result(K_NULLERR, 8'd0);
		end else begin
			add_result(K_BYTE, num_val);
			ph = PH_STR;
			in_string(c);
		end
	endtask

	task automatic decode_char(logic [7:0] c, logic st);
		int n0;
		int d;
		n0 = decoded_q.size();
		if (st) begin
			num_val = 8'd0;
			num_nz  = 1'b0;
			ph      = PH_STR;
			add_result(K_BYTE, c);
		end else begin
			case (ph)
				PH_STR: in_string(c);
				PH_ESC: begin
					ph = PH_STR;
					case (c)
						CH_NUL: begin
							ph = PH_IDLE;
							add_result(K_NULLERR, 8'd0);
						end
						CH_N: add_result(K_BYTE, BY_NL);
						CH_T: add_result(K_BYTE, BY_TAB);
						CH_V: add_result(K_BYTE, BY_VT);
						CH_B: add_result(K_BYTE, BY_BS);
						CH_R: add_result(K_BYTE, BY_CR);
						CH_F: add_result(K_BYTE, BY_FF);
						CH_A: add_result(K_BYTE, BY_BEL);
						CH_X: begin
							num_val = 8'd0;
							num_nz  = 1'b0;
							ph      = PH_HEXF;
						end
						default: begin
							if (c >= CH_0 && c <= CH_7) begin
								num_val = {5'd0, c[2:0]};
								num_nz  = (c != CH_0);
								ph      = PH_OCT;
							end else begin
								add_result(K_BYTE, c);
							end
						end
					endcase
				end
				PH_HEXF, PH_HEX: begin
					d = hex_val(c);
					if (d >= 0) begin
						num_val = {num_val[3:0], d[3:0]};
						if (d != 0)
							num_nz = 1'b1;
						ph = PH_HEX;
					end else if (ph == PH_HEXF) begin
						ph = PH_IDLE;
						add_result(K_NULLERR, 8'd0);
					end else begin
						close_number(c);
					end
				end
				PH_OCT: begin
					if (c >= CH_0 && c <= CH_7) begin
						num_val = {num_val[4:0], c[2:0]};
						if (c != CH_0)
							num_nz = 1'b1;
					end else begin
						close_number(c);
					end
				end
				default: ph = PH_IDLE;
			endcase
		end
		if (decoded_q.size() > n0)
			decoded_q[decoded_q.size() - 1].last = 1'b1;
	endtask

	task automatic report_mismatch(string what, int exp_v, int got_v);
		n_err++;
		if (n_err <= 40)
			$display("%0t: %s: expected %0d, got %0d", $time, what, exp_v, got_v);
	endtask

	task automatic push_char(logic [7:0] c, logic st);
		chr_beat_t b;
		b.ch    = c;
		b.st    = st;
		b.drain = 1'b0;
		pending_chars.push_back(b);
	endtask

	task automatic push_drain();
		chr_beat_t b;
		b.ch    = 8'd0;
		b.st    = 1'b0;
		b.drain = 1'b1;
		pending_chars.push_back(b);
	endtask

	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		c = 8'($urandom_range(1, 255));
		while (c == CH_DQUOT || c == CH_BSL)
			c = 8'($urandom_range(1, 255));
		return c;
	endfunction

	task automatic gen_string();
		int nseg;
		int sel;
		int nd;
		bit zeros;
		logic [7:0] c;
		c = ($urandom_range(0, 7) == 0) ? 8'($urandom) : CH_DQUOT;
		push_char(c, 1'b1);
		n_gen++;
		nseg = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 8);
		repeat (nseg) begin
			sel   = $urandom_range(0, 99);
			zeros = ($urandom_range(0, 4) == 0);
			nd    = $urandom_range(1, 4);
			if (sel < 40) begin
				push_char(plain_char(), 1'b0);
				n_gen++;
			end else if (sel < 60) begin
				push_char(CH_BSL, 1'b0);
				push_char(esc_set[$urandom_range(0, esc_set.len() - 1)], 1'b0);
				n_gen += 2;
			end else if (sel < 65) begin
				push_char(CH_BSL, 1'b0);
				push_char(8'($urandom), 1'b0);
				n_gen += 2;
			end else if (sel < 80) begin
				push_char(CH_BSL, 1'b0);
				push_char(CH_X, 1'b0);
				n_gen += 2 + nd;
				repeat (nd) begin
					c = zeros ? CH_0 : hex_digits[$urandom_range(0, hex_digits.len() - 1)];
					push_char(c, 1'b0);
				end
			end else if (sel < 95) begin
				push_char(CH_BSL, 1'b0);
				n_gen += 1 + nd;
				repeat (nd) begin
					c = zeros ? CH_0 : CH_0 + 8'($urandom_range(0, 7));
					push_char(c, 1'b0);
				end
			end else begin
				push_char(CH_BSL, 1'b0);
				push_char(CH_X, 1'b0);
				push_char(plain_char(), 1'b0);
				n_gen += 3;
			end
		end
		sel = $urandom_range(0, 19);
		if (sel < 15) begin
			push_char(CH_DQUOT, 1'b0);
			n_gen++;
		end else if (sel < 18) begin
			push_char(CH_NUL, 1'b0);
			n_gen++;
		end
	endtask

	// sender: bursts and gaps, prediction on each accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chr_if.valid     <= 1'b0;
			chr_if.in_char   <= 8'd0;
			chr_if.start_req <= 1'b0;
			burst_left       <= 0;
			gap_left         <= 0;
			n_chr            <= 0;
		end else begin
			if (chr_if.valid && chr_if.ready) begin
				decode_char(chr_if.in_char, chr_if.start_req);
				n_chr <= n_chr + 1;
			end
			if (!(chr_if.valid && !chr_if.ready)) begin
				drive_v = 1'b0;
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
				end else if (pending_chars.size() > 0) begin
					if (pending_chars[0].drain) begin
						if (decoded_q.size() == 0)
							void'(pending_chars.pop_front());
					end else begin
						nxt_beat = pending_chars.pop_front();
						drive_v  = 1'b1;
						chr_if.in_char   <= nxt_beat.ch;
						chr_if.start_req <= nxt_beat.st;
						if (burst_left <= 1) begin
							burst_left <= $urandom_range(1, 24);
							gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
						end else begin
							burst_left <= burst_left - 1;
						end
					end
				end
				chr_if.valid <= drive_v;
			end
		end
	end

	// receiver: compare each result beat, stall on a changing pattern and once for a long hold
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			hold_left    <= 0;
			held_once    <= 1'b0;
			stall_mode   <= 0;
			pat_cnt      <= 6'd0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				if (decoded_q.size() == 0) begin
					report_mismatch("result beat with nothing pending, kind", -1,
						int'(res_if.kind));
				end else begin
					exp_res = decoded_q.pop_front();
					if (res_if.out_byte !== exp_res.val)
						report_mismatch("out_byte", int'(exp_res.val), int'(res_if.out_byte));
					if (res_if.kind !== exp_res.kind)
						report_mismatch("kind", int'(exp_res.kind), int'(res_if.kind));
					if (res_if.last !== exp_res.last)
						report_mismatch("last", int'(exp_res.last), int'(res_if.last));
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				ready_nxt = 1'b0;
			end else if (!held_once && n_chr >= 600) begin
				held_once <= 1'b1;
				hold_left <= HOLD_LEN;
				ready_nxt = 1'b0;
			end else begin
				pat_cnt <= pat_cnt + 6'd1;
				if (pat_cnt == 6'd0)
					stall_mode <= $urandom_range(0, 3);
				case (stall_mode)
					0: ready_nxt = 1'b1;
					1: ready_nxt = ($urandom_range(0, 9) >= 3);
					2: ready_nxt = pat_cnt[0];
					default: ready_nxt = ($urandom_range(0, 9) >= 7);
				endcase
			end
			res_if.ready <= ready_nxt;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((chr_if.valid && chr_if.ready) || (res_if.valid && res_if.ready))
				idle_cnt <= 0;
			else
				idle_cnt <= idle_cnt + 1;
			if (idle_cnt >= IDLE_LIMIT) begin
				$display("escaped_string_decoder_core_tb: FAIL");
				$finish;
			end
		end
	end

	initial begin
		arst_n           = 1'b0;
		n_gen            = 0;

		push_char(CH_DQUOT, 1'b1);
		push_char(8'hFF, 1'b0);
		push_char(CH_BSL, 1'b0);
		push_char(CH_N, 1'b0);
		push_char(CH_BSL, 1'b0);
		push_char("q", 1'b0);
		push_char(CH_BSL, 1'b0);
		push_char(CH_X, 1'b0);
		push_char("A", 1'b0);
		push_char(CH_DQUOT, 1'b0);
		push_char(CH_NUL, 1'b1);
		push_char(CH_BSL, 1'b0);
		push_char("4", 1'b0);
		push_char(CH_0, 1'b0);
		push_char(CH_0, 1'b0);
		push_char(CH_NUL, 1'b0);
		push_char("z", 1'b0);
		push_char(CH_DQUOT, 1'b1);
		push_char(CH_BSL, 1'b0);
		push_char(CH_X, 1'b0);
		push_char("g", 1'b0);
		push_char(CH_DQUOT, 1'b1);
		push_char(CH_BSL, 1'b0);
		push_char(CH_NUL, 1'b0);
		push_char(CH_DQUOT, 1'b1);
		push_char(CH_BSL, 1'b0);
		push_char(CH_X, 1'b0);
		push_char("5", 1'b0);
		push_char(8'h80, 1'b1);
		push_char(CH_BSL, 1'b0);
		push_char(CH_0, 1'b0);
		push_char(CH_0, 1'b0);
		push_char("a", 1'b0);
		push_drain();

		while (n_gen < NUM_ITEMS) begin
			if ($urandom_range(0, 5) == 0)
				repeat ($urandom_range(1, 3))
					push_char(8'($urandom), 1'b0);
			gen_string();
			if (n_gen >= NUM_ITEMS / 2 && n_gen < NUM_ITEMS / 2 + 40)
				push_drain();
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_chars.size() != 0 || chr_if.valid)
			@(posedge clk);
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);

		if (decoded_q.size() != 0)
			report_mismatch("results never delivered", 0, decoded_q.size());
		if (n_err == 0)
			$display("escaped_string_decoder_core_tb: PASS");
		else
			$display("escaped_string_decoder_core_tb: FAIL");
		$finish;
	end

endmodule

/* escaped_string_decoder_core.f */
+incdir+hw/rtl
hw/rtl/escd_pkg.sv
hw/rtl/escd_in_if.sv
hw/rtl/escd_out_if.sv
hw/rtl/escd_front.sv
hw/rtl/escd_fifo.sv
hw/rtl/escd_back.sv
hw/rtl/escaped_string_decoder_core.sv
tb/sv/escaped_string_decoder_core_tb.sv
